/* hw/rtl/nps_pkg.sv */
// Shared types and field widths for the priority scheduler.
package nps_pkg;

    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int JIDX_W  = 4;
    localparam int TIME_W  = 21;
    localparam int WAIT_W  = 20;
    localparam int WSUM_W  = 24;
    localparam int TSUM_W  = 25;

    // One stored job entry
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } job_t;

endpackage

/* hw/rtl/nonpreemptive_priority_scheduler.sv */
// Non-preemptive priority scheduler: job store, scan control and result path.
//
// Jobs load one per cycle (start high while busy low). The item with last_item
// set raises busy and schedules the stored set; busy falls at the edge that
// puts out the final result. For each job to be completed the job memory
// streams through the candidate tracker (one read issued per cycle, each
// entry evaluated in the cycle after its registered read, then the last
// evaluation is drained), followed by the completion, turnaround, waiting
// and sum arithmetic states. Each result is shown for one cycle with
// out_valid; the receiver cannot stall it.
module nonpreemptive_priority_scheduler
    import nps_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [ARR_W-1:0]   arrival_time,
    input  logic [BURST_W-1:0] burst_time,
    input  logic [PRIO_W-1:0]  job_priority,
    input  logic               last_item,
    output logic               out_valid,
    output logic [JIDX_W-1:0]  job_index,
    output logic [TIME_W-1:0]  completion_time,
    output logic [WAIT_W-1:0]  waiting_time,
    output logic [TIME_W-1:0]  turnaround_time,
    output logic [WSUM_W-1:0]  total_wait,
    output logic [TSUM_W-1:0]  total_turnaround,
    output logic               last_result
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CT,
        S_TAT,
        S_WT,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   iss_cnt_reg;
    logic [CNT_W-1:0]   pick_cnt_reg;
    logic               eval_vld_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic [MAX_PROCS-1:0] done_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [WAIT_W-1:0]  wt_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [TSUM_W-1:0]  tsum_reg;
    logic               busy_reg;
    logic               out_valid_reg;
    logic [JIDX_W-1:0]  job_index_reg;
    logic [TIME_W-1:0]  completion_reg;
    logic [WAIT_W-1:0]  waiting_reg;
    logic [TIME_W-1:0]  turnaround_reg;
    logic [WSUM_W-1:0]  total_wait_reg;
    logic [TSUM_W-1:0]  total_tat_reg;
    logic               last_result_reg;

    // job memory, one read port with registered data
    job_t               mem [MAX_PROCS];
    job_t               rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               accept;
    logic               load_ok;
    job_t               wr_data;

    // tracker interface
    logic               pick_clear;
    job_t               win;
    logic [IDX_W-1:0]   win_idx;
    logic               win_gap;
    logic [TIME_W-1:0]  base_time;
    logic [WSUM_W-1:0]  wsum_sum;
    logic               final_pick;

    assign accept  = start && !busy_reg;
    assign load_ok = count_reg < CNT_MAX;
    assign wr_data = '{arrival: arrival_time, burst: burst_time, prio: job_priority};
    assign rd_addr = iss_cnt_reg[IDX_W-1:0];

    // memory write on load, read every cycle
    always_ff @(posedge clk) begin
        if (accept && load_ok)
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // tracker is cleared on entry to a scan
    assign pick_clear = (state_reg == S_IDLE) || (state_reg == S_OUT);

    nps_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (pick_clear),
        .eval     (eval_vld_reg && (state_reg == S_SCAN)),
        .entry    (rd_data_reg),
        .idx      (eval_idx_reg),
        .done     (done_reg[eval_idx_reg]),
        .cur_time (time_reg),
        .win      (win),
        .win_idx  (win_idx),
        .win_gap  (win_gap)
    );

    // start of run for the winner: now, or its arrival across an idle gap
    assign base_time  = win_gap ? TIME_W'(win.arrival) : time_reg;
    assign wsum_sum   = wsum_reg + WSUM_W'(wt_reg);
    assign final_pick = (pick_cnt_reg + CNT_W'(1)) == count_reg;

    // sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            iss_cnt_reg     <= '0;
            pick_cnt_reg    <= '0;
            eval_vld_reg    <= 1'b0;
            eval_idx_reg    <= '0;
            done_reg        <= '0;
            time_reg        <= '0;
            tat_reg         <= '0;
            wt_reg          <= '0;
            wsum_reg        <= '0;
            tsum_reg        <= '0;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            job_index_reg   <= '0;
            completion_reg  <= '0;
            waiting_reg     <= '0;
            turnaround_reg  <= '0;
            total_wait_reg  <= '0;
            total_tat_reg   <= '0;
            last_result_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (load_ok)
                            count_reg <= count_reg + CNT_W'(1);
                        if (last_item) begin
                            busy_reg     <= 1'b1;
                            iss_cnt_reg  <= '0;
                            pick_cnt_reg <= '0;
                            eval_vld_reg <= 1'b0;
                            state_reg    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue one read per cycle, evaluate it in the cycle after
                    if (iss_cnt_reg < count_reg) begin
                        eval_vld_reg <= 1'b1;
                        eval_idx_reg <= iss_cnt_reg[IDX_W-1:0];
                        iss_cnt_reg  <= iss_cnt_reg + CNT_W'(1);
                    end
                    else begin
                        eval_vld_reg <= 1'b0;
                        if (!eval_vld_reg)
                            state_reg <= S_CT;
                    end
                end
                S_CT: begin
                    time_reg          <= base_time + TIME_W'(win.burst);
                    done_reg[win_idx] <= 1'b1;
                    state_reg         <= S_TAT;
                end
                S_TAT: begin
                    tat_reg   <= time_reg - TIME_W'(win.arrival);
                    state_reg <= S_WT;
                end
                S_WT: begin
                    wt_reg    <= WAIT_W'(tat_reg - TIME_W'(win.burst));
                    tsum_reg  <= tsum_reg + TSUM_W'(tat_reg);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    out_valid_reg   <= 1'b1;
                    job_index_reg   <= JIDX_W'(win_idx);
                    completion_reg  <= time_reg;
                    waiting_reg     <= wt_reg;
                    turnaround_reg  <= tat_reg;
                    total_wait_reg  <= wsum_sum;
                    total_tat_reg   <= tsum_reg;
                    last_result_reg <= final_pick;
                    if (final_pick) begin
                        // end of set: clear for the next one
                        count_reg <= '0;
                        done_reg  <= '0;
                        time_reg  <= '0;
                        wsum_reg  <= '0;
                        tsum_reg  <= '0;
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else begin
                        wsum_reg     <= wsum_sum;
                        pick_cnt_reg <= pick_cnt_reg + CNT_W'(1);
                        iss_cnt_reg  <= '0;
                        eval_vld_reg <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = busy_reg;
    assign out_valid        = out_valid_reg;
    assign job_index        = job_index_reg;
    assign completion_time  = completion_reg;
    assign waiting_time     = waiting_reg;
    assign turnaround_time  = turnaround_reg;
    assign total_wait       = total_wait_reg;
    assign total_turnaround = total_tat_reg;
    assign last_result      = last_result_reg;

endmodule

/* hw/rtl/nps_pick.sv */
// Candidate tracker: folds scanned job entries into the next job to run.
module nps_pick
    import nps_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              eval,
    input  job_t              entry,
    input  logic [IDX_W-1:0]  idx,
    input  logic              done,
    input  logic [TIME_W-1:0] cur_time,
    output job_t              win,
    output logic [IDX_W-1:0]  win_idx,
    output logic              win_gap
);

    // best job already arrived
    logic             a_found_reg;
    job_t             a_best_reg;
    logic [IDX_W-1:0] a_idx_reg;
    // best job at the earliest pending arrival, used across an idle gap
    logic             g_found_reg;
    job_t             g_best_reg;
    logic [IDX_W-1:0] g_idx_reg;

    logic arrived;
    logic a_take;
    logic g_take;

    assign arrived = !done && (TIME_W'(entry.arrival) <= cur_time);

    // strict beats only: entries come in ascending index order
    assign a_take = arrived && (!a_found_reg
                    || (entry.prio > a_best_reg.prio)
                    || ((entry.prio == a_best_reg.prio)
                        && (entry.arrival < a_best_reg.arrival)));

    assign g_take = !done && (!g_found_reg
                    || (entry.arrival < g_best_reg.arrival)
                    || ((entry.arrival == g_best_reg.arrival)
                        && (entry.prio > g_best_reg.prio)));

    // found flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_found_reg <= 1'b0;
            g_found_reg <= 1'b0;
        end
        else if (clear) begin
            a_found_reg <= 1'b0;
            g_found_reg <= 1'b0;
        end
        else if (eval) begin
            if (a_take)
                a_found_reg <= 1'b1;
            if (g_take)
                g_found_reg <= 1'b1;
        end
    end

    // candidate payload
    always_ff @(posedge clk) begin
        if (eval && !clear) begin
            if (a_take) begin
                a_best_reg <= entry;
                a_idx_reg  <= idx;
            end
            if (g_take) begin
                g_best_reg <= entry;
                g_idx_reg  <= idx;
            end
        end
    end

    // winner: arrived job if any, else jump to the next arrival
    assign win_gap = !a_found_reg;
    assign win     = a_found_reg ? a_best_reg : g_best_reg;
    assign win_idx = a_found_reg ? a_idx_reg : g_idx_reg;

endmodule
